[rtl/core/lsm_pkg.sv]
// Package: shared types, constants and codes of the line substring matcher.
`timescale 1ns / 1ps

package lsm_pkg;

  // Default sizes handed to the top level
  localparam int LSM_LINE_STORE  = 1024;
  localparam int LSM_MAX_PATTERN = 16;

  // Fixed widths of the transaction fields
  localparam int LSM_BYTE_W     = 8;
  localparam int LSM_LEN_W      = 10;
  localparam int LSM_PLEN_CFG_W = 5;
  localparam int LSM_PAT_REG_W  = 64;
  localparam int LSM_PAT_BYTES  = 2 * LSM_PAT_REG_W / LSM_BYTE_W;

  // Configuration port
  localparam int LSM_CFG_IDX_W  = 2;
  localparam int LSM_CFG_DATA_W = LSM_PAT_REG_W;
  localparam logic [LSM_CFG_IDX_W-1:0] LSM_REG_PAT_LOW  = 2'd0;
  localparam logic [LSM_CFG_IDX_W-1:0] LSM_REG_PAT_HIGH = 2'd1;
  localparam logic [LSM_CFG_IDX_W-1:0] LSM_REG_PAT_LEN  = 2'd2;

  localparam logic [LSM_BYTE_W-1:0] LSM_NEWLINE = 8'd10;

  // Queue between front and back
  localparam int LSM_QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    LSM_OP_BYTE,
    LSM_OP_NEWLINE,
    LSM_OP_EOF
  } lsm_op_t;

  typedef struct packed {
    logic [LSM_BYTE_W-1:0] data_byte;
    logic                  end_of_file;
  } lsm_in_t;

  typedef struct packed {
    logic                 line_matched;
    logic [LSM_LEN_W-1:0] line_length;
    logic                 line_truncated;
    logic                 file_done;
    logic                 file_status;
  } lsm_out_t;

  // Head of the queue as seen by the back part
  typedef struct packed {
    logic                  valid;
    lsm_op_t               op;
    logic [LSM_BYTE_W-1:0] data_byte;
  } lsm_qhead_t;

endpackage

[rtl/core/line_substring_matcher.sv]
// Top level: fixed-string line search over a byte stream.
`timescale 1ns / 1ps

// Each input transaction is one byte or an end-of-file mark. Bytes are grouped into lines by
// newline; for every newline, and for every end-of-file mark, one result transaction reports
// whether the configured pattern (up to MAX_PATTERN bytes, programmed through the pattern and
// length registers, zero length matching every line) occurs in the stored line, how many
// bytes were stored (at most LINE_STORE-1, further bytes are dropped and the line flagged
// truncated) and, on end of file, whether any line of the file matched. The block takes one
// transaction per clock while not stalled: the front part accepts and classifies bytes into a
// four-entry queue, the back part shifts each byte into a window of the newest MAX_PATTERN bytes
// and compares it with the pattern in parallel in the same cycle. A result is registered when its
// newline or end-of-file mark is taken from the queue; ordinary bytes are consumed without
// waiting on the result side, and only a terminator meeting a held result register waits, so
// input stalls only once the queue has filled behind such a terminator. Write configuration
// only while the block is idle.

module line_substring_matcher
  import lsm_pkg::*;
#(
  parameter int LINE_STORE  = LSM_LINE_STORE,
  parameter int MAX_PATTERN = LSM_MAX_PATTERN
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [LSM_CFG_IDX_W-1:0]  cfg_index,
  input  logic [LSM_CFG_DATA_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  lsm_in_t                   in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output lsm_out_t                  out_data
);

  lsm_qhead_t q_head;
  logic       q_pop;

  // accept and classify each transaction
  lsm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  // advance the window and report per line and per file
  lsm_back #(
    .LINE_STORE  (LINE_STORE),
    .MAX_PATTERN (MAX_PATTERN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[rtl/core/lsm_front.sv]
// Front part: accepts input transactions, classifies them and queues them.
`timescale 1ns / 1ps

module lsm_front
  import lsm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  lsm_in_t    in_data,
  output lsm_qhead_t q_head,
  input  logic       q_pop
);

  localparam int PW = $clog2(LSM_QUEUE_DEPTH);
  localparam int CW = $clog2(LSM_QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(LSM_QUEUE_DEPTH);

  typedef struct packed {
    lsm_op_t               op;
    logic [LSM_BYTE_W-1:0] data_byte;
  } lsm_entry_t;

  lsm_entry_t          mem_r [LSM_QUEUE_DEPTH];
  logic [PW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                push;
  lsm_entry_t          entry;

  assign in_stall = (cnt_r == FULL_CNT);
  assign push     = in_valid && !in_stall;

  // classify the incoming transaction
  always_comb begin
    entry.data_byte = in_data.data_byte;
    if (in_data.end_of_file) begin
      entry.op = LSM_OP_EOF;
    end else if (in_data.data_byte == LSM_NEWLINE) begin
      entry.op = LSM_OP_NEWLINE;
    end else begin
      entry.op = LSM_OP_BYTE;
    end
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_comb begin
    q_head.valid     = (cnt_r != '0);
    q_head.op        = mem_r[rd_ptr_r].op;
    q_head.data_byte = mem_r[rd_ptr_r].data_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= entry;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && cnt_r == '0))
    else $error("queue popped while empty");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("queue fill count out of range");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    push && !q_pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue fill count out of step");

endmodule

[rtl/core/lsm_back.sv]
// Back part: line window, pattern compare, per-line and per-file status, result register.
`timescale 1ns / 1ps

module lsm_back
  import lsm_pkg::*;
#(
  parameter int LINE_STORE  = LSM_LINE_STORE,
  parameter int MAX_PATTERN = LSM_MAX_PATTERN
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [LSM_CFG_IDX_W-1:0]  cfg_index,
  input  logic [LSM_CFG_DATA_W-1:0] cfg_wdata,
  input  lsm_qhead_t                q_head,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output lsm_out_t                  out_data
);

  localparam int CW  = $clog2(LINE_STORE);
  localparam int PLW = $clog2(MAX_PATTERN + 1);
  localparam int PXW = (PLW > LSM_PLEN_CFG_W) ? PLW : LSM_PLEN_CFG_W;
  localparam int EW  = (CW > PLW) ? CW : PLW;
  localparam logic [CW-1:0]  CNT_LAST = CW'(LINE_STORE - 1);
  localparam logic [PXW-1:0] PLEN_MAX = PXW'(MAX_PATTERN);

  logic [LSM_PAT_REG_W-1:0]  pat_lo_r, pat_hi_r;
  logic [LSM_PLEN_CFG_W-1:0] plen_cfg_r;

  logic [LSM_BYTE_W-1:0] win_r   [MAX_PATTERN];
  logic [LSM_BYTE_W-1:0] win_nxt [MAX_PATTERN];
  logic [LSM_BYTE_W-1:0] win_sh  [MAX_PATTERN];
  logic [LSM_BYTE_W-1:0] aligned [MAX_PATTERN];
  logic [LSM_BYTE_W-1:0] pat     [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] eq;

  logic [CW-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic          match_r, match_nxt;
  logic          ovf_r, ovf_nxt;
  logic          fany_r, fany_nxt;
  logic          out_valid_r, out_valid_nxt;
  lsm_out_t      out_data_r, out_data_nxt;

  logic [2*LSM_PAT_REG_W-1:0] pat_bits;
  logic [PXW-1:0]             plen_x;
  logic [PLW-1:0]             plen;
  logic                       plen_zero;
  logic                       store;
  logic                       byte_hit;
  logic                       line_hit;
  logic                       eof_hit;
  logic                       out_free;
  logic [LSM_LEN_W+CW-1:0]    len_ext;

  // active pattern length, saturated to the window depth
  always_comb begin
    plen_x    = {{(PXW - LSM_PLEN_CFG_W){1'b0}}, plen_cfg_r};
    plen_x    = (plen_x > PLEN_MAX) ? PLEN_MAX : plen_x;
    plen      = plen_x[PLW-1:0];
    plen_zero = (plen == '0);
  end

  assign pat_bits = {pat_hi_r, pat_lo_r};

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_pat
    if (j < LSM_PAT_BYTES) begin : g_cfg
      assign pat[j] = pat_bits[LSM_BYTE_W*j +: LSM_BYTE_W];
    end else begin : g_zero
      assign pat[j] = '0;
    end
  end

  assign store   = (cnt_r < CNT_LAST);
  assign cnt_inc = cnt_r + 1'b1;

  // shift the new byte in at the newest end
  always_comb begin
    win_sh[0] = q_head.data_byte;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      win_sh[i] = win_r[i-1];
    end
  end

  // line the window up with the pattern: pattern byte j meets window byte plen-1-j
  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      aligned[j] = '0;
      for (int k = 0; k < MAX_PATTERN; k++) begin
        if (32'(plen) == k + j + 1) begin
          aligned[j] = win_sh[k];
        end
      end
      eq[j] = (j >= 32'(plen)) || (aligned[j] == pat[j]);
    end
  end

  assign byte_hit = !plen_zero && (EW'(cnt_inc) >= EW'(plen)) && (&eq);

  assign out_free = !out_valid_r || !out_stall;
  assign line_hit = plen_zero || match_r;
  assign eof_hit  = (cnt_r != '0) && line_hit;
  assign len_ext  = {{LSM_LEN_W{1'b0}}, cnt_r};

  always_comb begin
    win_nxt       = win_r;
    cnt_nxt       = cnt_r;
    match_nxt     = match_r;
    ovf_nxt       = ovf_r;
    fany_nxt      = fany_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    q_pop         = 1'b0;
    if (q_head.valid) begin
      case (q_head.op)
        LSM_OP_BYTE: begin
          q_pop = 1'b1;
          if (store) begin
            win_nxt = win_sh;
            cnt_nxt = cnt_inc;
            if (byte_hit) begin
              match_nxt = 1'b1;
            end
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        LSM_OP_NEWLINE: begin
          if (out_free) begin
            q_pop                       = 1'b1;
            out_valid_nxt               = 1'b1;
            out_data_nxt.line_matched   = line_hit;
            out_data_nxt.line_length    = len_ext[LSM_LEN_W-1:0];
            out_data_nxt.line_truncated = ovf_r;
            out_data_nxt.file_done      = 1'b0;
            out_data_nxt.file_status    = 1'b0;
            fany_nxt                    = fany_r || line_hit;
            win_nxt                     = '{default: '0};
            cnt_nxt                     = '0;
            match_nxt                   = 1'b0;
            ovf_nxt                     = 1'b0;
          end
        end
        LSM_OP_EOF: begin
          if (out_free) begin
            q_pop                       = 1'b1;
            out_valid_nxt               = 1'b1;
            out_data_nxt.line_matched   = eof_hit;
            out_data_nxt.line_length    = len_ext[LSM_LEN_W-1:0];
            out_data_nxt.line_truncated = (cnt_r != '0) && ovf_r;
            out_data_nxt.file_done      = 1'b1;
            out_data_nxt.file_status    = !(fany_r || eof_hit);
            fany_nxt                    = 1'b0;
            win_nxt                     = '{default: '0};
            cnt_nxt                     = '0;
            match_nxt                   = 1'b0;
            ovf_nxt                     = 1'b0;
          end
        end
        default: begin
          q_pop = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r   <= '0;
      pat_hi_r   <= '0;
      plen_cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        LSM_REG_PAT_LOW:  pat_lo_r   <= cfg_wdata;
        LSM_REG_PAT_HIGH: pat_hi_r   <= cfg_wdata;
        LSM_REG_PAT_LEN:  plen_cfg_r <= cfg_wdata[LSM_PLEN_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= '{default: '0};
      cnt_r       <= '0;
      match_r     <= 1'b0;
      ovf_r       <= 1'b0;
      fany_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      win_r       <= win_nxt;
      cnt_r       <= cnt_nxt;
      match_r     <= match_nxt;
      ovf_r       <= ovf_nxt;
      fany_r      <= fany_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_term_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && (q_head.op == LSM_OP_NEWLINE || q_head.op == LSM_OP_EOF) |=> out_valid_r)
    else $error("line terminator popped without a result");

  a_ovf_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> cnt_r == CNT_LAST)
    else $error("truncation flagged on a line that is not full");

  a_match_needs_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    match_r |-> cnt_r != '0)
    else $error("match flagged on an empty line");

endmodule
